// ----- rtl/adr_pkg.sv -----
`timescale 1ns / 1ps

package adr_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int INDEX_BITS    = 16;
    localparam int THR_BITS      = 15;
    localparam int GAP_BITS      = 16;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 16;
    localparam int IN_DATA_BITS  = 16;
    localparam int OUT_DATA_BITS = 32;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [INDEX_BITS-1:0] INDEX_MAX = '1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_DEV_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_GAP       = 1'b1;

    localparam logic [THR_BITS-1:0] THR_RESET = 15'd164;
    localparam logic [GAP_BITS-1:0] GAP_RESET = 16'd100;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIRST,
        ST_READ,
        ST_SUM,
        ST_DIFF,
        ST_DECIDE,
        ST_CTRL,
        ST_POINT,
        ST_NEXT,
        ST_FLUSH_SET,
        ST_TRAIL,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          buf_end;
    } t_item;

    typedef struct packed {
        logic                          push;
        logic                          close;
        logic                          buf_end;
        logic signed [SAMPLE_BITS-1:0] value;
        logic [INDEX_BITS-1:0]         index;
    } t_emit_cmd;

endpackage

// ----- rtl/adr_ram.sv -----
`timescale 1ns / 1ps

module adr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 52,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [WIDTH-1:0]  o_rdata_a,
    output logic [WIDTH-1:0]  o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ----- rtl/adr_front.sv -----
`timescale 1ns / 1ps

module adr_front import adr_pkg::*; #(
    parameter int MAX_SAMPLES = 65536,
    localparam int POS_W = $clog2(MAX_SAMPLES + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [IN_DATA_BITS-1:0] s_axis_tdata,   // [15:0] sample_value
    input  logic                    s_axis_tlast,   // buffer_end
    output logic                    o_q_valid,
    output t_item                   o_q_item,
    output logic [POS_W-1:0]        o_q_pos,
    input  logic                    i_q_pop
);

    localparam int QP_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item            r_q_item [QUEUE_DEPTH];
    logic [POS_W-1:0] r_q_pos  [QUEUE_DEPTH];
    logic [QP_W-1:0]  r_wp;
    logic [QP_W-1:0]  r_rp;
    logic [CNT_W-1:0] r_count;
    logic [POS_W-1:0] r_pos;

    logic [QP_W-1:0]  n_wp;
    logic [QP_W-1:0]  n_rp;
    logic [CNT_W-1:0] n_count;
    logic [POS_W-1:0] n_pos;
    logic             w_push;

    assign s_axis_tready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign w_push        = s_axis_tvalid && s_axis_tready;
    assign o_q_valid     = (r_count != '0);
    assign o_q_item      = r_q_item[r_rp];
    assign o_q_pos       = r_q_pos[r_rp];

    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        n_pos   = r_pos;
        if (w_push) begin
            n_wp = r_wp + QP_W'(1);
            if (s_axis_tlast) begin
                n_pos = '0;
            end else if (r_pos == POS_W'(MAX_SAMPLES)) begin
                n_pos = r_pos;
            end else begin
                n_pos = r_pos + POS_W'(1);
            end
        end
        if (i_q_pop) begin
            n_rp = r_rp + QP_W'(1);
        end
        if (w_push && !i_q_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!w_push && i_q_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
            r_pos   <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
            r_pos   <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q_item[r_wp] <= '{sample: $signed(s_axis_tdata), buf_end: s_axis_tlast};
            r_q_pos[r_wp]  <= r_pos;
        end
    end

endmodule

// ----- rtl/adr_core.sv -----
`timescale 1ns / 1ps

module adr_core import adr_pkg::*; #(
    parameter int HALF_WINDOW = 25,
    parameter int MAX_SAMPLES = 65536,
    localparam int POS_W = $clog2(MAX_SAMPLES + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  t_item               i_q_item,
    input  logic [POS_W-1:0]    i_q_pos,
    output logic                o_q_pop,
    input  logic [THR_BITS-1:0] i_dev_thr,
    input  logic [GAP_BITS-1:0] i_max_gap,
    output t_emit_cmd           o_cmd,
    input  logic                i_cmd_ready
);

    localparam int WIN_LEN  = 2 * HALF_WINDOW + 1;
    localparam int RING_LEN = 2 * HALF_WINDOW + 2;
    localparam int PTR_W    = $clog2(RING_LEN);
    localparam int K_W      = $clog2(HALF_WINDOW + 1);
    localparam int SUM_W    = SAMPLE_BITS + $clog2(WIN_LEN);
    localparam int DIFF_W   = SUM_W + 1;
    localparam int LIMIT_W  = THR_BITS + $clog2(WIN_LEN);
    localparam int CMP_W    = ((POS_W > INDEX_BITS) ? POS_W : INDEX_BITS) + 1;

    localparam logic signed [SUM_W-1:0] WIN_LEN_S = SUM_W'(WIN_LEN);
    localparam logic [LIMIT_W-1:0]      WIN_LEN_U = LIMIT_W'(WIN_LEN);
    localparam logic [PTR_W-1:0]        RING_LAST = PTR_W'(RING_LEN - 1);

    function automatic logic [PTR_W-1:0] ring_back(input logic [PTR_W-1:0] ptr,
                                                   input logic [PTR_W-1:0] age);
        logic [PTR_W:0] t;
        t = {1'b0, ptr} - {1'b0, age};
        if (t[PTR_W]) begin
            t = t + (PTR_W + 1)'(RING_LEN);
        end
        return t[PTR_W-1:0];
    endfunction

    function automatic logic [INDEX_BITS-1:0] sat_idx(input logic [CMP_W-1:0] v);
        return (v > CMP_W'(INDEX_MAX)) ? INDEX_MAX : v[INDEX_BITS-1:0];
    endfunction

    t_state                        r_state, n_state;
    logic [PTR_W-1:0]              r_ptr, n_ptr;
    logic [PTR_W-1:0]              r_addr_v, n_addr_v;
    logic [PTR_W-1:0]              r_addr_s, n_addr_s;
    logic signed [SAMPLE_BITS-1:0] r_x, n_x;
    logic                          r_end, n_end;
    logic [POS_W-1:0]              r_pos, n_pos;
    logic                          r_add, n_add;
    logic                          r_sub, n_sub;
    logic                          r_dec, n_dec;
    logic [POS_W-1:0]              r_i, n_i;
    logic                          r_flush, n_flush;
    logic [K_W-1:0]                r_k, n_k;
    logic signed [SUM_W-1:0]       r_sum, n_sum;
    logic signed [SAMPLE_BITS-1:0] r_v, n_v;
    logic signed [SUM_W-1:0]       r_v51, n_v51;
    logic signed [DIFF_W-1:0]      r_diff, n_diff;
    logic signed [CMP_W-1:0]       r_gapd, n_gapd;
    logic                          r_ctrl_ok, n_ctrl_ok;
    logic signed [SAMPLE_BITS-1:0] r_prev, n_prev;
    logic [INDEX_BITS-1:0]         r_lpp, n_lpp;
    logic [LIMIT_W-1:0]            r_limit;

    logic                          w_we;
    logic [PTR_W-1:0]              w_ptr_inc;
    logic signed [SAMPLE_BITS-1:0] w_rd_v;
    logic signed [SAMPLE_BITS-1:0] w_rd_s;
    logic signed [SUM_W-1:0]       w_add_term;
    logic signed [SUM_W-1:0]       w_sub_term;
    logic signed [DIFF_W-1:0]      w_lim;
    logic                          w_dev;
    logic                          w_gap;

    adr_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (RING_LEN)
    ) u_ring (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_ptr_inc),
        .i_wdata   (i_q_item.sample),
        .i_raddr_a (r_addr_v),
        .i_raddr_b (r_addr_s),
        .o_rdata_a (w_rd_v),
        .o_rdata_b (w_rd_s)
    );

    assign w_ptr_inc  = (r_ptr == RING_LAST) ? '0 : r_ptr + PTR_W'(1);
    assign w_add_term = r_add ? SUM_W'(r_x) : SUM_W'(0);
    assign w_sub_term = r_sub ? SUM_W'(w_rd_s) : SUM_W'(0);
    assign w_lim      = $signed(DIFF_W'(r_limit));
    assign w_dev      = (r_diff > w_lim) || (r_diff < -w_lim);
    assign w_gap      = r_gapd > $signed(CMP_W'(i_max_gap));

    always_comb begin
        n_state   = r_state;
        n_ptr     = r_ptr;
        n_addr_v  = r_addr_v;
        n_addr_s  = r_addr_s;
        n_x       = r_x;
        n_end     = r_end;
        n_pos     = r_pos;
        n_add     = r_add;
        n_sub     = r_sub;
        n_dec     = r_dec;
        n_i       = r_i;
        n_flush   = r_flush;
        n_k       = r_k;
        n_sum     = r_sum;
        n_v       = r_v;
        n_v51     = r_v51;
        n_diff    = r_diff;
        n_gapd    = r_gapd;
        n_ctrl_ok = r_ctrl_ok;
        n_prev    = r_prev;
        n_lpp     = r_lpp;
        o_q_pop   = 1'b0;
        w_we      = 1'b0;
        o_cmd     = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop  = 1'b1;
                    w_we     = 1'b1;
                    n_ptr    = w_ptr_inc;
                    n_addr_v = ring_back(w_ptr_inc, PTR_W'(HALF_WINDOW));
                    n_addr_s = ring_back(w_ptr_inc, PTR_W'(WIN_LEN));
                    n_x      = i_q_item.sample;
                    n_end    = i_q_item.buf_end;
                    n_pos    = i_q_pos;
                    n_add    = 1'b1;
                    n_sub    = i_q_pos >= POS_W'(WIN_LEN);
                    n_dec    = i_q_pos >= POS_W'(HALF_WINDOW);
                    n_i      = i_q_pos - POS_W'(HALF_WINDOW);
                    n_flush  = 1'b0;
                    n_state  = (i_q_pos == '0) ? ST_FIRST : ST_READ;
                end
            end
            ST_FIRST: begin
                o_cmd.push  = 1'b1;
                o_cmd.value = r_x;
                o_cmd.index = '0;
                if (i_cmd_ready) begin
                    n_state = ST_SUM;
                end
            end
            ST_READ: begin
                n_state = ST_SUM;
            end
            ST_SUM: begin
                n_sum   = r_sum + w_add_term - w_sub_term;
                n_v     = w_rd_v;
                n_v51   = SUM_W'(w_rd_v) * WIN_LEN_S;
                n_state = r_dec ? ST_DIFF : ST_NEXT;
            end
            ST_DIFF: begin
                n_diff    = DIFF_W'(r_v51) - DIFF_W'(r_sum);
                n_gapd    = $signed(CMP_W'(r_i)) - $signed(CMP_W'(r_lpp));
                n_ctrl_ok = (CMP_W'(r_lpp) + CMP_W'(1)) < CMP_W'(r_i);
                n_state   = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (w_dev && r_ctrl_ok) begin
                    n_state = ST_CTRL;
                end else if (w_dev || w_gap) begin
                    n_state = ST_POINT;
                end else begin
                    n_prev  = r_v;
                    n_state = ST_NEXT;
                end
            end
            ST_CTRL: begin
                o_cmd.push  = 1'b1;
                o_cmd.value = r_prev;
                o_cmd.index = sat_idx(CMP_W'(r_i) - CMP_W'(1));
                if (i_cmd_ready) begin
                    n_state = ST_POINT;
                end
            end
            ST_POINT: begin
                o_cmd.push  = 1'b1;
                o_cmd.value = r_v;
                o_cmd.index = sat_idx(CMP_W'(r_i));
                if (i_cmd_ready) begin
                    n_lpp   = sat_idx(CMP_W'(r_i));
                    n_prev  = r_v;
                    n_state = ST_NEXT;
                end
            end
            ST_NEXT: begin
                if (!r_flush) begin
                    if (r_end) begin
                        n_flush = 1'b1;
                        n_k     = K_W'(HALF_WINDOW - 1);
                        n_state = ST_FLUSH_SET;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end else if (r_k == '0) begin
                    n_state = ST_TRAIL;
                end else begin
                    n_k     = r_k - K_W'(1);
                    n_state = ST_FLUSH_SET;
                end
            end
            ST_FLUSH_SET: begin
                if (r_pos >= POS_W'(r_k)) begin
                    n_addr_v = ring_back(r_ptr, PTR_W'(r_k));
                    n_addr_s = ring_back(r_ptr, PTR_W'(r_k) + PTR_W'(HALF_WINDOW + 1));
                    n_add    = 1'b0;
                    n_sub    = r_pos >= (POS_W'(r_k) + POS_W'(HALF_WINDOW + 1));
                    n_dec    = 1'b1;
                    n_i      = r_pos - POS_W'(r_k);
                    n_state  = ST_READ;
                end else if (r_k == '0) begin
                    n_state = ST_TRAIL;
                end else begin
                    n_k = r_k - K_W'(1);
                end
            end
            ST_TRAIL: begin
                if (CMP_W'(r_lpp) < CMP_W'(r_pos)) begin
                    o_cmd.push  = 1'b1;
                    o_cmd.value = r_prev;
                    o_cmd.index = sat_idx(CMP_W'(r_pos));
                    if (i_cmd_ready) begin
                        n_state = ST_FINISH;
                    end
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                o_cmd.close   = 1'b1;
                o_cmd.buf_end = r_end;
                if (i_cmd_ready) begin
                    if (r_end) begin
                        n_sum   = '0;
                        n_prev  = '0;
                        n_lpp   = '0;
                        n_flush = 1'b0;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ptr   <= '0;
            r_flush <= 1'b0;
            r_sum   <= '0;
            r_prev  <= '0;
            r_lpp   <= '0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_flush <= n_flush;
            r_sum   <= n_sum;
            r_prev  <= n_prev;
            r_lpp   <= n_lpp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr_v  <= n_addr_v;
        r_addr_s  <= n_addr_s;
        r_x       <= n_x;
        r_end     <= n_end;
        r_pos     <= n_pos;
        r_add     <= n_add;
        r_sub     <= n_sub;
        r_dec     <= n_dec;
        r_i       <= n_i;
        r_k       <= n_k;
        r_v       <= n_v;
        r_v51     <= n_v51;
        r_diff    <= n_diff;
        r_gapd    <= n_gapd;
        r_ctrl_ok <= n_ctrl_ok;
        r_limit   <= LIMIT_W'(i_dev_thr) * WIN_LEN_U;
    end

endmodule

// ----- rtl/adr_out.sv -----
`timescale 1ns / 1ps

module adr_out import adr_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_emit_cmd                i_cmd,
    output logic                     o_cmd_ready,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata,  // [15:0] point_value, [31:16] point_index
    output logic                     m_axis_tlast,  // last_of_run
    output logic                     m_axis_tuser   // buffer_done
);

    logic                          r_hold_valid, n_hold_valid;
    logic signed [SAMPLE_BITS-1:0] r_hold_value, n_hold_value;
    logic [INDEX_BITS-1:0]         r_hold_index, n_hold_index;
    logic                          r_out_valid, n_out_valid;
    logic [OUT_DATA_BITS-1:0]      r_out_data, n_out_data;
    logic                          r_out_last, n_out_last;
    logic                          r_out_user, n_out_user;

    logic w_out_free;
    logic w_take;
    logic w_move;

    assign w_out_free  = !r_out_valid || m_axis_tready;
    assign o_cmd_ready = !r_hold_valid || w_out_free;
    assign w_take      = (i_cmd.push || i_cmd.close) && o_cmd_ready;
    assign w_move      = w_take && r_hold_valid;

    always_comb begin
        n_hold_valid = r_hold_valid;
        n_hold_value = r_hold_value;
        n_hold_index = r_hold_index;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_data   = r_out_data;
        n_out_last   = r_out_last;
        n_out_user   = r_out_user;
        if (w_move) begin
            n_out_valid = 1'b1;
            n_out_data  = {r_hold_index, r_hold_value};
            n_out_last  = i_cmd.close;
            n_out_user  = i_cmd.close && i_cmd.buf_end;
        end
        if (w_take) begin
            n_hold_valid = i_cmd.push;
            if (i_cmd.push) begin
                n_hold_value = i_cmd.value;
                n_hold_index = i_cmd.index;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold_value <= n_hold_value;
        r_hold_index <= n_hold_index;
        r_out_data   <= n_out_data;
        r_out_last   <= n_out_last;
        r_out_user   <= n_out_user;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_user;

endmodule

// ----- rtl/adaptive_deviation_resampler_top.sv -----
`timescale 1ns / 1ps

// Resamples buffers of signed Q1.15 samples into (value, index) points. Each sample is compared
// with the average of a centered window of 2*HALF_WINDOW+1 samples, clipped at the buffer
// edges, and a point is sent when the deviation exceeds the threshold or when the index gap
// since the last point exceeds max_gap; a deviating point is preceded by its neighbor as a
// control point when that neighbor lies after the last point, sample 0 is always sent, and the
// item marked with tlast flushes the pending decisions and sends a trailing point when the last
// point lies before it. The input side takes one sample per cycle into a four-entry queue while
// the queue has room; a single sequencer behind it, which shares one window RAM with two
// registered read ports, finishes each sample before it pops the next one, and a buffer-end
// sample also works through each of the HALF_WINDOW pending decisions in turn. The output
// register lets the next transaction be prepared while the current one waits for m_axis_tready.
module adaptive_deviation_resampler_top import adr_pkg::*; #(
    parameter int HALF_WINDOW = 25,
    parameter int MAX_SAMPLES = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,   // [15:0] sample_value
    input  logic                     s_axis_tlast,   // buffer_end
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata,   // [15:0] point_value, [31:16] point_index
    output logic                     m_axis_tlast,   // last_of_run
    output logic                     m_axis_tuser,   // buffer_done
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int POS_W = $clog2(MAX_SAMPLES + 1);

    logic [THR_BITS-1:0] r_dev_thr;
    logic [GAP_BITS-1:0] r_max_gap;

    logic             w_q_valid;
    t_item            w_q_item;
    logic [POS_W-1:0] w_q_pos;
    logic             w_q_pop;
    t_emit_cmd        w_cmd;
    logic             w_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_thr <= THR_RESET;
            r_max_gap <= GAP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DEV_THRESHOLD: r_dev_thr <= i_cfg_data[THR_BITS-1:0];
                CFG_MAX_GAP:       r_max_gap <= i_cfg_data[GAP_BITS-1:0];
            endcase
        end
    end

    adr_front #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .o_q_valid     (w_q_valid),
        .o_q_item      (w_q_item),
        .o_q_pos       (w_q_pos),
        .i_q_pop       (w_q_pop)
    );

    adr_core #(
        .HALF_WINDOW (HALF_WINDOW),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_item    (w_q_item),
        .i_q_pos     (w_q_pos),
        .o_q_pop     (w_q_pop),
        .i_dev_thr   (r_dev_thr),
        .i_max_gap   (r_max_gap),
        .o_cmd       (w_cmd),
        .i_cmd_ready (w_cmd_ready)
    );

    adr_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_cmd_ready   (w_cmd_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_q_valid)
        else $error("Sequencer popped an empty queue.");

    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.push && w_cmd.close))
        else $error("Point push and item close issued together.");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
        else $error("Buffer done flag on a transaction that is not the last of its item.");

endmodule

// ----- tb/adr_point_checker.sv -----
`timescale 1ns / 1ps

module adr_point_checker import adr_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    input  logic                     s_axis_tready,
    input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
    input  logic                     s_axis_tlast,
    input  logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    input  logic [OUT_DATA_BITS-1:0] m_axis_tdata,
    input  logic                     m_axis_tlast,
    input  logic                     m_axis_tuser,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output int                       o_fail_count,
    output int                       o_points_due
);

    localparam int     HALF     = 25;
    localparam longint WIN      = 2 * HALF + 1;
    localparam int     RING     = 2 * HALF + 2;
    localparam int     POS_SAT  = 65536;

    typedef struct packed {
        logic [INDEX_BITS-1:0] value;
        logic [INDEX_BITS-1:0] index;
        logic                  run_end;
        logic                  buf_done;
    } t_point;

    logic signed [SAMPLE_BITS-1:0] ring_mem [RING];
    int unsigned                   ring_wr;
    longint                        window_sum;
    longint                        prev_val;
    int unsigned                   last_pt;
    int unsigned                   pos_cnt;
    logic [THR_BITS-1:0]           dev_thr;
    logic [GAP_BITS-1:0]           gap_limit;
    t_point                        due_points [$];
    int                            mismatches;

    initial begin
        o_fail_count = 0;
        o_points_due = 0;
        mismatches   = 0;
    end

    function automatic int unsigned clip_index(input int unsigned idx);
        return (idx > 65535) ? 65535 : idx;
    endfunction

    function automatic longint sample_aged(input int unsigned age);
        return longint'(ring_mem[(ring_wr + RING - (age % RING)) % RING]);
    endfunction

    function automatic void queue_point(input longint v, input int unsigned idx);
        t_point p;
        p.value    = v[15:0];
        p.index    = INDEX_BITS'(clip_index(idx));
        p.run_end  = 1'b0;
        p.buf_done = 1'b0;
        due_points.push_back(p);
    endfunction

    function automatic void judge_sample(input int unsigned pos, input int unsigned age);
        int unsigned idx;
        longint      v;
        longint      diff;
        bit          dev;
        bit          gap;
        idx  = pos - age;
        v    = sample_aged(age);
        diff = WIN * v - window_sum;
        if (diff < 0) begin
            diff = -diff;
        end
        dev = diff > WIN * longint'(dev_thr);
        gap = longint'(idx) - longint'(last_pt) > longint'(gap_limit);
        if (dev || gap) begin
            if (dev && longint'(last_pt) + 1 < longint'(idx)) begin
                queue_point(prev_val, idx - 1);
            end
            queue_point(v, idx);
            last_pt = clip_index(idx);
        end
        prev_val = v;
    endfunction

    function automatic void absorb_sample(input logic signed [SAMPLE_BITS-1:0] x, input bit fin);
        int unsigned pos;
        int          prior_count;
        int          k;
        t_point      tail;
        pos         = pos_cnt;
        prior_count = due_points.size();
        ring_wr = (ring_wr + 1) % RING;
        ring_mem[ring_wr] = x;
        window_sum += longint'(x);
        if (pos >= WIN) begin
            window_sum -= sample_aged(WIN);
        end
        if (pos == 0) begin
            queue_point(longint'(x), 0);
        end
        if (pos >= HALF) begin
            judge_sample(pos, HALF);
        end
        if (fin) begin
            for (k = HALF - 1; k >= 0; k--) begin
                if (pos >= k) begin
                    if (pos >= k + HALF + 1) begin
                        window_sum -= sample_aged(k + HALF + 1);
                    end
                    judge_sample(pos, k);
                end
            end
            if (last_pt < pos) begin
                queue_point(prev_val, pos);
            end
            window_sum = 0;
            prev_val   = 0;
            last_pt    = 0;
            pos_cnt    = 0;
        end else begin
            pos_cnt = (pos >= POS_SAT) ? POS_SAT : pos + 1;
        end
        if (due_points.size() > prior_count) begin
            tail = due_points.pop_back();
            tail.run_end  = 1'b1;
            tail.buf_done = fin;
            due_points.push_back(tail);
        end
    endfunction

    function automatic void clear_model();
        foreach (ring_mem[n]) begin
            ring_mem[n] = '0;
        end
        ring_wr    = 0;
        window_sum = 0;
        prev_val   = 0;
        last_pt    = 0;
        pos_cnt    = 0;
        dev_thr    = THR_RESET;
        gap_limit  = GAP_RESET;
        due_points.delete();
    endfunction

    always @(posedge i_clk) begin : watch
        t_point want;
        t_point got;
        if (!i_rst_n) begin
            clear_model();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_DEV_THRESHOLD) begin
                    dev_thr = i_cfg_data[THR_BITS-1:0];
                end else if (i_cfg_index == CFG_MAX_GAP) begin
                    gap_limit = i_cfg_data[GAP_BITS-1:0];
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                absorb_sample(s_axis_tdata[SAMPLE_BITS-1:0], s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.value    = m_axis_tdata[15:0];
                got.index    = m_axis_tdata[31:16];
                got.run_end  = m_axis_tlast;
                got.buf_done = m_axis_tuser;
                if (due_points.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected point transaction: value %0d index %0d last %0b done %0b",
                                 $signed(got.value), got.index, got.run_end, got.buf_done);
                    end
                end else begin
                    want = due_points.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("point mismatch: expected value %0d index %0d last %0b done %0b",
                                     $signed(want.value), want.index, want.run_end, want.buf_done);
                            $display("                got value %0d index %0d last %0b done %0b",
                                     $signed(got.value), got.index, got.run_end, got.buf_done);
                        end
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_points_due <= due_points.size();
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb import adr_pkg::*;;

    localparam int CYCLE_LIMIT  = 10000000;
    localparam int RANDOM_ITEMS = 420;
    localparam int SETTLE       = 64;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [IN_DATA_BITS-1:0]  s_axis_tdata = '0;
    logic                     s_axis_tlast = 1'b0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;
    logic                     m_axis_tlast;
    logic                     m_axis_tuser;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    int fail_count;
    int points_due;
    int cycles = 0;
    int ready_hold = 0;
    int level = 0;
    int items_sent;
    int buffers_sent;

    adaptive_deviation_resampler_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    adr_point_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_points_due  (points_due)
    );

    initial begin
        forever begin
            #10 i_clk = ~i_clk;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[adaptive_deviation_resampler_top] ERROR");
            $finish;
        end
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 88) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 40);
    endfunction

    function automatic int busy_len();
        if ($urandom_range(0, 99) < 80) begin
            return $urandom_range(0, 8);
        end
        return $urandom_range(40, 200);
    endfunction

    always @(posedge i_clk) begin : ready_gen
        int stall;
        if (ready_hold > 0) begin
            ready_hold--;
        end else if (m_axis_tready) begin
            stall = idle_len();
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                ready_hold = stall - 1;
            end else begin
                ready_hold = busy_len();
            end
        end else begin
            m_axis_tready <= 1'b1;
            ready_hold = busy_len();
        end
    end

    function automatic logic signed [15:0] clip16(input int v);
        if (v > 32767) begin
            return 16'sd32767;
        end
        if (v < -32768) begin
            return -16'sd32768;
        end
        return v[15:0];
    endfunction

    // Style 0 is white noise over the full range, style 1 a wandering level with
    // noise, spikes and steps, and style 2 a flat level with rare spikes.
    function automatic logic signed [15:0] shape_sample(input int style);
        logic [15:0] raw;
        int          r;
        int          s;
        int          spike;
        r     = $urandom_range(0, 99);
        spike = int'($urandom_range(2000, 30000));
        if ($urandom_range(0, 1) == 1) begin
            spike = -spike;
        end
        if (style == 0) begin
            raw = 16'($urandom);
            return raw;
        end
        if (style == 1) begin
            level = clip16(level + int'($urandom_range(0, 400)) - 200);
            s = level + int'($urandom_range(0, 120)) - 60;
            if (r < 4) begin
                s += spike;
            end else if (r < 6) begin
                level = clip16(level + spike);
            end
            return clip16(s);
        end
        s = level;
        if (r < 5) begin
            s += spike;
        end
        return clip16(s);
    endfunction

    task automatic push_sample(input logic signed [15:0] v, input bit fin, input int gap);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tlast  <= fin;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (points_due != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_config(input int thr, input int gap);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_DEV_THRESHOLD;
        i_cfg_data  <= CFG_DATA_BITS'(thr);
        @(posedge i_clk);
        i_cfg_index <= CFG_MAX_GAP;
        i_cfg_data  <= CFG_DATA_BITS'(gap);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_buffer(input int len, input int style, input bit burst);
        int n;
        level = int'($urandom_range(0, 40000)) - 20000;
        for (n = 0; n < len; n++) begin
            push_sample(shape_sample(style), n == len - 1, burst ? 0 : idle_len());
        end
    endtask

    task automatic send_list(input logic signed [15:0] vals [$]);
        int n;
        for (n = 0; n < vals.size(); n++) begin
            push_sample(vals[n], n == vals.size() - 1, idle_len());
        end
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            case ($urandom_range(0, 6))
                0: return 1;
                1: return 2;
                2: return 25;
                3: return 26;
                4: return 51;
                5: return 52;
                default: return 53;
            endcase
        end
        if (r < 70) begin
            return $urandom_range(1, 30);
        end
        if (r < 93) begin
            return $urandom_range(31, 90);
        end
        return $urandom_range(91, 250);
    endfunction

    function automatic int pick_thr();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) begin
            return 0;
        end
        if (r < 40) begin
            return 32767;
        end
        if (r < 80) begin
            return $urandom_range(0, 600);
        end
        return $urandom_range(0, 32767);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            return 0;
        end
        if (r < 30) begin
            return 1;
        end
        if (r < 40) begin
            return 65535;
        end
        return $urandom_range(2, 200);
    endfunction

    initial begin
        int len;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single-sample buffers at both extremes, then a buffer whose first sample deviates.
        send_list('{16'sh7fff});
        send_list('{-16'sh8000});
        send_list('{16'sh7fff, 0, 0, 0, 0, 0, -16'sh8000, 0});
        drain();

        set_config(0, 0);
        send_list('{1, -1, 0, 5, -32768, 32767});
        drain();

        set_config(32767, 1);
        send_list('{32767, -32768, 100, -100, 0});
        drain();

        items_sent   = 0;
        buffers_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if (buffers_sent % 2 == 0) begin
                drain();
                set_config(pick_thr(), pick_gap());
            end
            len = pick_len();
            send_buffer(len, $urandom_range(0, 2), $urandom_range(0, 3) == 0);
            items_sent += len;
            buffers_sent++;
        end
        drain();

        if (fail_count == 0) begin
            $display("[adaptive_deviation_resampler_top] OK");
        end else begin
            $display("[adaptive_deviation_resampler_top] ERROR");
        end
        $finish;
    end

endmodule
